// ===== design/imm_pkg.sv =====
// Package for the integer matrix multiply engine.
// Holds field widths, item and element kind codes, register indexes,
// the sequencer state type and the element width helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int ROW_W     = 6;
    localparam int VAL_W     = 64;
    localparam int DIM_REG_W = 7;
    localparam int EK_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 80;
    localparam int HALF_W    = 32;

    localparam logic [1:0] ITEM_LOAD_A  = 2'd0;
    localparam logic [1:0] ITEM_LOAD_B  = 2'd1;
    localparam logic [1:0] ITEM_REQUEST = 2'd2;

    localparam logic [EK_W-1:0] ELEM_INT32 = 2'd0;
    localparam logic [EK_W-1:0] ELEM_INT64 = 2'd1;
    localparam logic [EK_W-1:0] ELEM_INT8  = 2'd2;
    localparam logic [EK_W-1:0] ELEM_UINT8 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_KIND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_DRAIN,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        MUL_LL,
        MUL_HL,
        MUL_LH
    } mul_op_t;

    function automatic logic [VAL_W-1:0] elem_mask(input logic [EK_W-1:0] ek);
        logic [VAL_W-1:0] m;
        case (ek)
            ELEM_INT32: m = 64'h0000_0000_FFFF_FFFF;
            ELEM_INT64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:    m = 64'h0000_0000_0000_00FF;
        endcase
        return m;
    endfunction

    function automatic logic [VAL_W-1:0] elem_extend(input logic [VAL_W-1:0] v,
                                                      input logic [EK_W-1:0] ek);
        logic [VAL_W-1:0] r;
        case (ek)
            ELEM_INT32: r = {{32{v[31]}}, v[31:0]};
            ELEM_INT64: r = v;
            ELEM_INT8:  r = {{56{v[7]}}, v[7:0]};
            default:    r = {56'd0, v[7:0]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/imm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the A and B element stores. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiply engine: element stores, dimension
// registers and a sequencer around one shared 32x32 multiplier and accumulator.
// Depends on imm_pkg and imm_ram.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_tvalid/s_tready   s_tdata: row, col, elem_value; s_tuser: kind
//  m_       out        m_tvalid/m_tready   m_tdata: out_row, out_col, product_value;
//                                          m_tuser: out_of_range
//  cfg_     in         cfg_we              cfg_index, cfg_data
//
// A request forms one 32x32 partial product per inner index for 8 and 32 bit
// elements and three for 64 bit elements, on the single multiplier that forms
// one 32x32 partial product per cycle. An out-of-range request skips the
// reads and the multiplier. The input is not ready while a request is in work,
// and a finished result waits for the output register to be free.
// Reset is synchronous and active low; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Bits from low: row[5:0], col[11:6], elem_value[75:12], zero padding.
    input  wire logic [imm_pkg::TDATA_W-1:0]       s_tdata,
    // Bits from low: kind[1:0].
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Bits from low: out_row[5:0], out_col[11:6], product_value[75:12], zero padding.
    output logic [imm_pkg::TDATA_W-1:0]            m_tdata,
    // Bits from low: out_of_range[0].
    output logic [0:0]                             m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [imm_pkg::DIM_REG_W-1:0]     cfg_data
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_W > imm_pkg::DIM_REG_W) ? DIM_W : imm_pkg::DIM_REG_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int ROW_W  = imm_pkg::ROW_W;
    localparam int VAL_W  = imm_pkg::VAL_W;
    localparam int HW     = imm_pkg::HALF_W;

    function automatic logic [CMP_W-1:0] eff_dim(input logic [imm_pkg::DIM_REG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w == '0) begin
            return CMP_W'(1);
        end else if (w > CMP_W'(MAX_DIM)) begin
            return CMP_W'(MAX_DIM);
        end
        return w;
    endfunction

    logic [imm_pkg::DIM_REG_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [imm_pkg::EK_W-1:0]      elem_kind_reg;

    imm_pkg::state_t  state_reg, state_next;
    imm_pkg::mul_op_t mul_op;
    logic [ROW_W-1:0] row_reg, row_next, col_reg, col_next;
    logic             oor_reg, oor_next;
    logic [DIM_W-1:0] k_reg, k_next, k_plus, rd_k;
    logic             rd_en, mul_go, term_done, acc_clr, load_out;
    logic [VAL_W-1:0] mul_reg, acc_reg, addend, mul_prod;
    logic             mvld_reg, mshift_reg;
    logic [HW-1:0]    mul_a, mul_b;

    logic             m_valid_reg, m_oor_reg;
    logic [ROW_W-1:0] m_row_reg, m_col_reg;
    logic [VAL_W-1:0] m_val_reg;

    logic [ROW_W-1:0] in_row, in_col;
    logic [VAL_W-1:0] in_val, wdata, a_rdata, b_rdata;
    logic [CMP_W-1:0] ra, kd, cb;
    logic             in_acc, a_we, b_we, req_oor, more;
    logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;

    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_val = s_tdata[75:12];
    assign ra     = eff_dim(rows_a_reg);
    assign kd     = eff_dim(inner_dim_reg);
    assign cb     = eff_dim(cols_b_reg);

    assign s_tready = (state_reg == imm_pkg::S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign a_we     = in_acc && (s_tuser == imm_pkg::ITEM_LOAD_A)
                      && (CMP_W'(in_row) < ra) && (CMP_W'(in_col) < kd);
    assign b_we     = in_acc && (s_tuser == imm_pkg::ITEM_LOAD_B)
                      && (CMP_W'(in_row) < kd) && (CMP_W'(in_col) < cb);
    assign req_oor  = (CMP_W'(in_row) >= ra) || (CMP_W'(in_col) >= cb);
    assign waddr    = {IDX_W'(in_row), IDX_W'(in_col)};
    assign wdata    = in_val & imm_pkg::elem_mask(elem_kind_reg);

    assign k_plus  = k_reg + DIM_W'(1);
    assign more    = CMP_W'(k_plus) < kd;
    assign a_raddr = {IDX_W'(row_reg), rd_k[IDX_W-1:0]};
    assign b_raddr = {rd_k[IDX_W-1:0], IDX_W'(col_reg)};

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= imm_pkg::DIM_REG_W'(64);
            inner_dim_reg <= imm_pkg::DIM_REG_W'(64);
            cols_b_reg    <= imm_pkg::DIM_REG_W'(64);
            elem_kind_reg <= imm_pkg::ELEM_INT32;
        end else if (cfg_we) begin
            case (cfg_index)
                imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                imm_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                imm_pkg::CFG_ELEM_KIND: elem_kind_reg <= cfg_data[imm_pkg::EK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imm_pkg::S_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        oor_reg <= oor_next;
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        oor_next   = oor_reg;
        rd_en      = 1'b0;
        rd_k       = k_reg;
        mul_go     = 1'b0;
        mul_op     = imm_pkg::MUL_LL;
        term_done  = 1'b0;
        acc_clr    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            imm_pkg::S_IDLE: begin
                if (in_acc && (s_tuser == imm_pkg::ITEM_REQUEST)) begin
                    row_next   = in_row;
                    col_next   = in_col;
                    oor_next   = req_oor;
                    k_next     = '0;
                    acc_clr    = 1'b1;
                    state_next = req_oor ? imm_pkg::S_FIN : imm_pkg::S_READ;
                end
            end
            imm_pkg::S_READ: begin
                rd_en      = 1'b1;
                state_next = imm_pkg::S_MUL0;
            end
            imm_pkg::S_MUL0: begin
                mul_go = 1'b1;
                mul_op = imm_pkg::MUL_LL;
                if (elem_kind_reg == imm_pkg::ELEM_INT64) begin
                    state_next = imm_pkg::S_MUL1;
                end else begin
                    term_done = 1'b1;
                end
            end
            imm_pkg::S_MUL1: begin
                mul_go     = 1'b1;
                mul_op     = imm_pkg::MUL_HL;
                state_next = imm_pkg::S_MUL2;
            end
            imm_pkg::S_MUL2: begin
                mul_go    = 1'b1;
                mul_op    = imm_pkg::MUL_LH;
                term_done = 1'b1;
            end
            imm_pkg::S_DRAIN: begin
                state_next = imm_pkg::S_FIN;
            end
            imm_pkg::S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = imm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = imm_pkg::S_IDLE;
            end
        endcase
        if (term_done) begin
            if (more) begin
                rd_en      = 1'b1;
                rd_k       = k_plus;
                k_next     = k_plus;
                state_next = imm_pkg::S_MUL0;
            end else begin
                state_next = imm_pkg::S_DRAIN;
            end
        end
    end

    always_comb begin
        case (mul_op)
            imm_pkg::MUL_HL: begin
                mul_a = a_rdata[VAL_W-1:HW];
                mul_b = b_rdata[HW-1:0];
            end
            imm_pkg::MUL_LH: begin
                mul_a = a_rdata[HW-1:0];
                mul_b = b_rdata[VAL_W-1:HW];
            end
            default: begin
                mul_a = a_rdata[HW-1:0];
                mul_b = b_rdata[HW-1:0];
            end
        endcase
    end

    assign mul_prod = VAL_W'(mul_a) * VAL_W'(mul_b);
    assign addend   = mshift_reg ? {mul_reg[HW-1:0], {HW{1'b0}}} : mul_reg;

    always_ff @(posedge aclk) begin
        if (mul_go) begin
            mul_reg    <= mul_prod;
            mshift_reg <= (mul_op != imm_pkg::MUL_LL);
        end
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (mvld_reg) begin
            acc_reg <= acc_reg + addend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= 1'b0;
        end else begin
            mvld_reg <= mul_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_row_reg <= row_reg;
            m_col_reg <= col_reg;
            m_oor_reg <= oor_reg;
            m_val_reg <= imm_pkg::elem_extend(acc_reg, elem_kind_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_val_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_oor_reg;

`ifndef NO_ASSERTIONS
    a_busy_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != imm_pkg::S_IDLE) |-> (!a_we && !b_we))
        else $error("store written while a request is in work");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == imm_pkg::S_FIN))
        else $error("result appeared without a finished request");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::S_MUL0 || state_reg == imm_pkg::S_MUL1
         || state_reg == imm_pkg::S_MUL2) |-> (CMP_W'(k_reg) < kd))
        else $error("inner index beyond inner dimension");

    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == imm_pkg::S_FIN) |-> !mvld_reg)
        else $error("partial product pending at result time");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_oor_reg) |-> (m_val_reg == '0))
        else $error("out-of-range result carries a nonzero value");
`endif

endmodule

`default_nettype wire
